>>> src/cfc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame checker.
`timescale 1ns / 1ps
package cfc_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int BYTE_W          = 8;
    localparam int CRC_W           = 16;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CRC_W-1:0] CRC_START = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY  = 16'h8408;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATUS_POSITION = 1'b0,
        CFG_CRC_ERROR_CODE  = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_READER   = 2'd1,
        FAULT_MISMATCH = 2'd2,
        FAULT_SHORT    = 2'd3
    } t_fault;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_end;
    } t_item;

    typedef struct packed {
        logic             frame_good;
        t_fault           fault_kind;
        logic [CRC_W-1:0] computed_crc;
    } t_verdict;

    // Reflected CRC-16 over one byte, least significant bit first.
    function automatic logic [CRC_W-1:0] crc16_feed(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W - BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> src/cfc_in_stage.sv
// Input register that holds one accepted byte until the frame core takes it.
`timescale 1ns / 1ps
module cfc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cfc_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output cfc_pkg::t_item o_item
);

    logic           r_valid;
    cfc_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> src/cfc_frame_core.sv
// Frame state (CRC, two-byte delay line, position, status flag) and the verdict logic.
`timescale 1ns / 1ps
module cfc_frame_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cfc_pkg::BYTE_W-1:0]    i_status_position,
    input  logic [cfc_pkg::BYTE_W-1:0]    i_crc_error_code,
    input  logic                          i_valid,
    input  cfc_pkg::t_item                i_item,
    input  logic                          i_out_free,
    output logic                          o_take,
    output logic                          o_res_valid,
    output cfc_pkg::t_verdict             o_verdict
);

    localparam int POS_W = cfc_pkg::POS_W;
    localparam int BW    = cfc_pkg::BYTE_W;

    logic [cfc_pkg::CRC_W-1:0] r_crc, n_crc;
    logic [BW-1:0]             r_held0, n_held0;
    logic [BW-1:0]             r_held1, n_held1;
    logic [POS_W-1:0]          r_pos, n_pos;
    logic                      r_flag, n_flag;

    logic                      flag_hit;
    logic [cfc_pkg::CRC_W-1:0] received;
    cfc_pkg::t_fault           fault;

    // A byte that ends a frame waits until the result register can take its verdict.
    assign o_take      = i_valid && (!i_item.frame_end || i_out_free);
    assign o_res_valid = o_take && i_item.frame_end;

    always_comb begin
        flag_hit = (r_pos < POS_W'(cfc_pkg::MAX_FRAME_BYTES))
                && ({{BW{1'b0}}, r_pos} == {{POS_W{1'b0}}, i_status_position})
                && (i_item.data_byte == i_crc_error_code);
        n_flag  = r_flag | flag_hit;
        n_crc   = (r_pos >= POS_W'(2)) ? cfc_pkg::crc16_feed(r_crc, r_held0) : r_crc;
        n_held0 = r_held1;
        n_held1 = i_item.data_byte;
        n_pos   = (r_pos < POS_W'(cfc_pkg::MAX_FRAME_BYTES)) ? r_pos + POS_W'(1) : r_pos;
    end

    // The last byte carries the high CRC byte and the one before it the low byte.
    always_comb begin
        received = {i_item.data_byte, r_held1};
        if (n_pos < POS_W'(3)) begin
            fault = cfc_pkg::FAULT_SHORT;
        end else if (n_flag) begin
            fault = cfc_pkg::FAULT_READER;
        end else if (received != n_crc) begin
            fault = cfc_pkg::FAULT_MISMATCH;
        end else begin
            fault = cfc_pkg::FAULT_NONE;
        end
        o_verdict.frame_good   = (fault == cfc_pkg::FAULT_NONE);
        o_verdict.fault_kind   = fault;
        o_verdict.computed_crc = n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= cfc_pkg::CRC_START;
            r_held0 <= '0;
            r_held1 <= '0;
            r_pos   <= '0;
            r_flag  <= 1'b0;
        end else if (o_take) begin
            if (i_item.frame_end) begin
                r_crc   <= cfc_pkg::CRC_START;
                r_held0 <= '0;
                r_held1 <= '0;
                r_pos   <= '0;
                r_flag  <= 1'b0;
            end else begin
                r_crc   <= n_crc;
                r_held0 <= n_held0;
                r_held1 <= n_held1;
                r_pos   <= n_pos;
                r_flag  <= n_flag;
            end
        end
    end

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(cfc_pkg::MAX_FRAME_BYTES))
        else $error("frame position ran past its saturation value");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_pos == '0) && (r_crc == cfc_pkg::CRC_START) && !r_flag)
        else $error("frame state not cleared after a verdict");

    a_short_keeps_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_verdict.fault_kind == cfc_pkg::FAULT_SHORT)
            |-> (o_verdict.computed_crc == cfc_pkg::CRC_START) && !o_verdict.frame_good)
        else $error("short frame reported a CRC other than the start value");

    a_early_crc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos < POS_W'(2)) |-> (r_crc == cfc_pkg::CRC_START))
        else $error("CRC moved before the delay line was full");

endmodule

>>> src/cfc_out_stage.sv
// Result register that holds one verdict until the downstream side takes it.
`timescale 1ns / 1ps
module cfc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  cfc_pkg::t_verdict i_verdict,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output cfc_pkg::t_verdict o_verdict
);

    logic              r_valid;
    cfc_pkg::t_verdict r_verdict;

    assign o_free    = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_verdict <= i_verdict;
        end
    end

endmodule

>>> src/crc16_frame_checker_unit.sv
// Top level of the CRC-16 response frame checker.
//
//  Channel  Dir  Signals                         Contents
//  s_axis   in   tvalid/tready/tdata/tlast       one frame byte, tlast on the last byte
//  m_axis   out  tvalid/tready/tdata/tuser       one verdict per frame
//  cfg      in   i_cfg_we/i_cfg_index/i_cfg_data register writes, no read-back
//
// One byte a cycle sustained unless a verdict waits on a stalled result; a byte goes
// from the input register through the unrolled 8-bit CRC update to the result
// register, which presents the verdict once the last byte has passed both registers.
// Reset is synchronous and active low and clears all frame state and both stage
// valid bits. A stalled result holds only the byte that ends the next frame; bytes
// inside a frame keep flowing.
`timescale 1ns / 1ps
module crc16_frame_checker_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
    input  logic                          s_axis_tlast,  // frame_end
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,  // [15:0] computed_crc
    output logic [2:0]                    m_axis_tuser,  // [0] frame_good, [2:1] fault_kind
    input  logic                          i_cfg_we,
    input  logic [cfc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);

    logic [cfc_pkg::BYTE_W-1:0] r_status_position;
    logic [cfc_pkg::BYTE_W-1:0] r_crc_error_code;

    cfc_pkg::t_item    in_item;
    cfc_pkg::t_item    held_item;
    logic              held_valid;
    logic              take;
    logic              out_free;
    logic              res_valid;
    cfc_pkg::t_verdict core_verdict;
    cfc_pkg::t_verdict out_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_position <= 8'd3;
            r_crc_error_code  <= 8'd0;
        end else if (i_cfg_we) begin
            case (cfc_pkg::t_cfg_index'(i_cfg_index))
                cfc_pkg::CFG_STATUS_POSITION: r_status_position <= i_cfg_data;
                cfc_pkg::CFG_CRC_ERROR_CODE:  r_crc_error_code  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item.data_byte = s_axis_tdata;
    assign in_item.frame_end = s_axis_tlast;

    cfc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    cfc_frame_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_status_position (r_status_position),
        .i_crc_error_code  (r_crc_error_code),
        .i_valid           (held_valid),
        .i_item            (held_item),
        .i_out_free        (out_free),
        .o_take            (take),
        .o_res_valid       (res_valid),
        .o_verdict         (core_verdict)
    );

    cfc_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (res_valid),
        .i_verdict (core_verdict),
        .o_free    (out_free),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_verdict (out_verdict)
    );

    assign m_axis_tdata = out_verdict.computed_crc;
    assign m_axis_tuser = {out_verdict.fault_kind, out_verdict.frame_good};

endmodule
